[hdl/rrq_pkg.sv]
// Shared types and constants for the round-robin ring queue.
// No dependencies; imported by every module of the queue.
package rrq_pkg;

    localparam int DEPTH  = 16;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int JOB_W  = 16;
    localparam int OCC_W  = 5;

    typedef enum logic [1:0] {
        FUNC_PUSH  = 2'd0,
        FUNC_POP   = 2'd1,
        FUNC_SLICE = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]       func;
        logic [JOB_W-1:0] job_time;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [JOB_W-1:0] head_value;
        logic             requeued;
        logic [OCC_W-1:0] occupancy;
    } out_beat_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    capture;
        logic    push_wr;
        logic    head_rd;
        logic    requeue_wr;
        logic    out_load;
        status_t out_status;
        logic    out_take_head;
    } rrq_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        func_t op;
        logic  empty;
        logic  full;
        logic  over_slice;
    } rrq_stat_t;

endpackage

[hdl/round_robin_ring_queue_core.sv]
// Round-robin ring queue: one operation per input beat, one result beat per operation.
// Push, no-op and empty pop/slice load the result from EXEC; a pop or slice of a held job
// loads it from FINISH, after the registered read of the job store.
// The next beat waits until the controller idles and the result register is free.
// Reset: pointers and count clear, quantum loads 10; store contents stay undefined.
// Depends on rrq_pkg, rrq_ctrl and rrq_datapath.
module round_robin_ring_queue_core
    import rrq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_beat_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_beat_t        out_data,
    input  logic             cfg_wr_en,
    input  logic [JOB_W-1:0] cfg_wr_data
);

    rrq_cmd_t  cmd;
    rrq_stat_t stat;

    rrq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    rrq_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_data     (in_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat),
        .out_data    (out_data)
    );

endmodule

[hdl/rrq_ctrl.sv]
// Sequencing state machine for the ring queue: handshakes and datapath commands.
// Depends on rrq_pkg.
module rrq_ctrl
    import rrq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    input  rrq_stat_t stat,
    output rrq_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Take a new beat only when idle and the result register is free or draining
    assign in_stall  = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign out_valid = out_valid_reg;

    // Decode state and operation into commands
    always_comb
    begin
        state_next        = state_reg;
        cmd               = '0;
        cmd.out_status    = STATUS_OK;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (stat.op)
                    FUNC_PUSH:
                    begin
                        cmd.push_wr    = !stat.full;
                        cmd.out_load   = 1'b1;
                        cmd.out_status = stat.full ? STATUS_OVERFLOW : STATUS_OK;
                        state_next     = ST_IDLE;
                    end
                    FUNC_POP, FUNC_SLICE:
                    begin
                        if (stat.empty)
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.out_status = STATUS_UNDERFLOW;
                            state_next     = ST_IDLE;
                        end
                        else
                        begin
                            cmd.head_rd = 1'b1;
                            state_next  = ST_FINISH;
                        end
                    end
                    default:
                    begin
                        cmd.out_load = 1'b1;
                        state_next   = ST_IDLE;
                    end
                endcase
            end
            ST_FINISH:
            begin
                cmd.requeue_wr    = (stat.op == FUNC_SLICE) && stat.over_slice;
                cmd.out_load      = 1'b1;
                cmd.out_take_head = 1'b1;
                state_next        = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Set valid on a result load, drop it when the beat is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[hdl/rrq_datapath.sv]
// Datapath of the ring queue: job store, pointers, count, quantum and result register.
// Depends on rrq_pkg.
module rrq_datapath
    import rrq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  in_beat_t         in_data,
    input  logic             cfg_wr_en,
    input  logic [JOB_W-1:0] cfg_wr_data,
    input  rrq_cmd_t         cmd,
    output rrq_stat_t        stat,
    output out_beat_t        out_data
);

    logic [JOB_W-1:0] job_store [DEPTH];

    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [JOB_W-1:0] slice_reg;
    func_t            op_reg;
    logic [JOB_W-1:0] job_reg;
    logic [JOB_W-1:0] head_reg;
    out_beat_t        out_reg;

    logic             wr_en;
    logic [JOB_W-1:0] wr_data;
    logic [JOB_W-1:0] remainder;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Status toward the controller
    assign stat.op         = op_reg;
    assign stat.empty      = (count_reg == '0);
    assign stat.full       = (count_reg == CNT_W'(DEPTH));
    assign stat.over_slice = (head_reg > slice_reg);

    assign remainder = head_reg - slice_reg;
    assign wr_en     = cmd.push_wr || cmd.requeue_wr;
    assign wr_data   = cmd.requeue_wr ? remainder : job_reg;

    // Advance pointers and count
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (cmd.head_rd)
        begin
            rd_ptr_next = ptr_inc(rd_ptr_reg);
            count_next  = count_reg - 1'b1;
        end
        if (wr_en)
        begin
            wr_ptr_next = ptr_inc(wr_ptr_reg);
            count_next  = count_reg + 1'b1;
        end
    end

    // Hold pointers, count and quantum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
            slice_reg  <= JOB_W'(10);
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (cfg_wr_en)
                slice_reg <= cfg_wr_data;
        end
    end

    // Job store: one write port, registered read of the head
    always_ff @(posedge clk)
    begin
        if (wr_en)
            job_store[wr_ptr_reg] <= wr_data;
        if (cmd.head_rd)
            head_reg <= job_store[rd_ptr_reg];
    end

    // Capture the operation and load the result register
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= func_t'(in_data.func);
            job_reg <= in_data.job_time;
        end
        if (cmd.out_load)
        begin
            out_reg.status     <= cmd.out_status;
            out_reg.head_value <= cmd.out_take_head ? head_reg : '0;
            out_reg.requeued   <= cmd.requeue_wr;
            out_reg.occupancy  <= OCC_W'(count_next);
        end
    end

    assign out_data = out_reg;

endmodule

[hdl/rrq_checker.sv]
// Port-level checks for the round-robin ring queue, bound to the top level.
// Depends on rrq_pkg and round_robin_ring_queue_core.
module rrq_checker
    import rrq_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_stall,
    input out_beat_t out_data
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // Overflow only with a full queue
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == STATUS_OVERFLOW)
        |-> (out_data.occupancy == OCC_W'(DEPTH)) && (out_data.head_value == '0))
        else $error("overflow reported with a queue that is not full");

    // Underflow leaves an empty queue and no head
    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == STATUS_UNDERFLOW)
        |-> (out_data.occupancy == '0) && (out_data.head_value == '0) && !out_data.requeued)
        else $error("underflow reported with entries held");

    // Requeue only on a good slice of a nonzero job
    a_requeue_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.requeued
        |-> (out_data.status == STATUS_OK) && (out_data.head_value != '0)
            && (out_data.occupancy != '0))
        else $error("requeue flagged on a failed or empty slice");

endmodule

bind round_robin_ring_queue_core rrq_checker u_rrq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

[tb/round_robin_ring_queue_core_tb.sv]
`timescale 1ns / 100ps
// Testbench for round_robin_ring_queue_core: directed and random push/pop/slice beats,
// each result beat checked against a local model of the ring queue and its quantum.
// Depends on rrq_pkg and the core RTL.
module round_robin_ring_queue_core_tb;
    import rrq_pkg::*;

    localparam int LIMIT_CYCLES   = 200000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int MIX_ITEMS      = 240;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             in_valid    = 1'b0;
    logic             in_stall;
    in_beat_t         in_data     = '0;
    logic             out_valid;
    logic             out_stall   = 1'b0;
    out_beat_t        out_data;
    logic             cfg_wr_en   = 1'b0;
    logic [JOB_W-1:0] cfg_wr_data = '0;

    // Local copy of the queue state and the quantum
    logic [JOB_W-1:0] job_copy [DEPTH];
    int               head_idx  = 0;
    int               tail_idx  = 0;
    int               job_count = 0;
    logic [JOB_W-1:0] quantum   = 16'd10;

    out_beat_t        expected_results [$];
    int               fail_count   = 0;
    int               cycle_count  = 0;

    // Receiver stall controls
    int               holdoff_req  = 0;
    int               holdoff_seen = 0;
    int               holdoff_left = 0;
    int               stall_mode   = 0;
    int               mode_left    = 0;

    round_robin_ring_queue_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #1 clk = ~clk;

    // Append a job at the tail of the local queue
    function automatic void store_tail(logic [JOB_W-1:0] value);
        job_copy[tail_idx] = value;
        tail_idx  = (tail_idx + 1) % DEPTH;
        job_count = job_count + 1;
    endfunction

    // Apply one operation to the local queue and return the result beat it yields
    function automatic out_beat_t apply_op(in_beat_t beat);
        out_beat_t        res;
        logic [JOB_W-1:0] head;
        res = '0;
        case (func_t'(beat.func))
            FUNC_PUSH:
            begin
                if (job_count == DEPTH)
                    res.status = STATUS_OVERFLOW;
                else
                    store_tail(beat.job_time);
            end
            FUNC_POP, FUNC_SLICE:
            begin
                if (job_count == 0)
                    res.status = STATUS_UNDERFLOW;
                else
                begin
                    head      = job_copy[head_idx];
                    head_idx  = (head_idx + 1) % DEPTH;
                    job_count = job_count - 1;
                    res.head_value = head;
                    // Requeue the remainder only while the job outlasts the quantum
                    if (func_t'(beat.func) == FUNC_SLICE && head > quantum)
                    begin
                        store_tail(head - quantum);
                        res.requeued = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        res.occupancy = job_count[OCC_W-1:0];
        return res;
    endfunction

    // Job times: full range, small, near the quantum, and the extremes
    function automatic logic [JOB_W-1:0] pick_job_time();
        int near;
        case ($urandom_range(0, 5))
            1: return JOB_W'($urandom_range(0, 31));
            2:
            begin
                near = int'(quantum) + int'($urandom_range(0, 4)) - 2;
                if (near < 0)
                    near = 0;
                if (near > 65535)
                    near = 65535;
                return near[JOB_W-1:0];
            end
            3:
            begin
                case ($urandom_range(0, 3))
                    0: return 16'd0;
                    1: return 16'd1;
                    2: return 16'hFFFE;
                    default: return 16'hFFFF;
                endcase
            end
            default: return JOB_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic func_t pick_op(int push_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            return FUNC_NOP;
        if (roll < 4 + (push_pct * 96) / 100)
            return FUNC_PUSH;
        return ($urandom_range(0, 1) != 0) ? FUNC_SLICE : FUNC_POP;
    endfunction

    function automatic bit field_bad(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Offer one beat and hold it until accepted; valid stays high afterwards
    task automatic send_op(input func_t op, input logic [JOB_W-1:0] job_time);
        in_beat_t beat;
        beat.func     = op;
        beat.job_time = job_time;
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.push_back(apply_op(beat));
    endtask

    task automatic idle_sender(input int gap);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
    endtask

    // Stop sending and let every outstanding result beat drain
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_quantum(input logic [JOB_W-1:0] value);
        wait_for_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        quantum = value;
    endtask

    // Random operations in bursts, with segments that lean toward filling or draining
    task automatic run_random_mix(input int n_items);
        int burst_left;
        int seg_left;
        int push_pct;
        int gap;
        burst_left = 0;
        seg_left   = 0;
        push_pct   = 50;
        for (int i = 0; i < n_items; i++)
        begin
            if (seg_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0: push_pct = 20;
                    1: push_pct = 50;
                    2: push_pct = 75;
                    default: push_pct = 95;
                endcase
                seg_left = $urandom_range(15, 60);
            end
            seg_left--;
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0)
                    idle_sender(gap);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            send_op(pick_op(push_pct), pick_job_time());
        end
    endtask

    task automatic test_empty_queue();
        send_op(FUNC_POP, 16'd0);
        send_op(FUNC_SLICE, 16'hFFFF);
        send_op(FUNC_NOP, JOB_W'($urandom_range(0, 65535)));
        send_op(FUNC_NOP, 16'hFFFF);
    endtask

    // Zero and maximum jobs, and heads at, below and above the quantum
    task automatic test_job_extremes();
        send_op(FUNC_PUSH, 16'd0);
        send_op(FUNC_PUSH, 16'hFFFF);
        send_op(FUNC_PUSH, 16'd1);
        send_op(FUNC_PUSH, 16'd10);
        send_op(FUNC_PUSH, 16'd11);
        send_op(FUNC_SLICE, 16'd0);
        send_op(FUNC_SLICE, 16'd0);
        send_op(FUNC_SLICE, 16'd0);
        send_op(FUNC_SLICE, 16'd0);
        send_op(FUNC_SLICE, 16'd0);
        send_op(FUNC_POP, 16'd0);
        send_op(FUNC_POP, 16'd0);
        send_op(FUNC_POP, 16'd0);
    endtask

    // Fill to the top, overflow, then slice while full
    task automatic test_full_queue();
        while (job_count < DEPTH)
            send_op(FUNC_PUSH, pick_job_time());
        send_op(FUNC_PUSH, 16'hFFFF);
        send_op(FUNC_SLICE, 16'd0);
        send_op(FUNC_POP, 16'd0);
    endtask

    task automatic test_quantum_sweep();
        set_quantum(16'd0);
        run_random_mix(MIX_ITEMS);
        set_quantum(16'd1);
        run_random_mix(MIX_ITEMS);
        set_quantum(16'hFFFF);
        run_random_mix(MIX_ITEMS);
        set_quantum(JOB_W'($urandom_range(2, 40)));
        run_random_mix(MIX_ITEMS);
        set_quantum(JOB_W'($urandom_range(41, 65534)));
        run_random_mix(MIX_ITEMS);
        set_quantum(16'd10);
        run_random_mix(MIX_ITEMS);
    endtask

    // Receiver holds off for a long stretch while beats keep coming
    task automatic test_output_holdoff();
        wait_for_results();
        holdoff_req++;
        for (int i = 0; i < 40; i++)
            send_op(pick_op(60), pick_job_time());
        wait_for_results();
    endtask

    // Receiver stall pattern, with an occasional long hold-off on request
    always @(posedge clk)
    begin
        if (holdoff_seen != holdoff_req)
        begin
            holdoff_seen = holdoff_req;
            holdoff_left = HOLDOFF_CYCLES;
        end
        if (holdoff_left > 0)
        begin
            holdoff_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(8, 80);
            end
            mode_left--;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 99) < 30);
                2: out_stall <= ($urandom_range(0, 99) < 75);
                default: out_stall <= ~out_stall;
            endcase
        end
    end

    // Compare each accepted result beat with the oldest expected one
    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result beat %h", out_data);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (field_bad("status", 32'(want.status), 32'(out_data.status)) |
                    field_bad("head_value", 32'(want.head_value),
                              32'(out_data.head_value)) |
                    field_bad("requeued", 32'(want.requeued), 32'(out_data.requeued)) |
                    field_bad("occupancy", 32'(want.occupancy),
                              32'(out_data.occupancy)))
                    fail_count++;
            end
        end
    end

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_job_extremes();
        test_full_queue();
        test_output_holdoff();
        test_quantum_sweep();
        test_output_holdoff();

        wait_for_results();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[sim.f]
hdl/rrq_pkg.sv
hdl/rrq_ctrl.sv
hdl/rrq_datapath.sv
hdl/round_robin_ring_queue_core.sv
hdl/rrq_checker.sv
tb/round_robin_ring_queue_core_tb.sv
